// ===== sv/vm16_pkg.sv =====
// shared constants, opcode codes, operand format table and alu result type
// for the vm16 cpu core; no dependencies
package vm16_pkg;

  localparam int unsigned REG_COUNT = 12;
  localparam int unsigned REG_IDX_W = 4;
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

  localparam logic [REG_IDX_W-1:0] R_IP  = 4'd0;
  localparam logic [REG_IDX_W-1:0] R_ACC = 4'd1;
  localparam logic [REG_IDX_W-1:0] R_R1  = 4'd2;
  localparam logic [REG_IDX_W-1:0] R_R8  = 4'd9;
  localparam logic [REG_IDX_W-1:0] R_SP  = 4'd10;
  localparam logic [REG_IDX_W-1:0] R_FP  = 4'd11;
  localparam logic [15:0] RESET_SP = 16'hffff - 16'd1;

  localparam logic [1:0] CMD_WR   = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_RD   = 2'd2;
  localparam logic [1:0] CMD_REG  = 2'd3;

  localparam logic [7:0] OP_MOV_LR  = 8'd0;
  localparam logic [7:0] OP_MOV_RR  = 8'd1;
  localparam logic [7:0] OP_MOV_RM  = 8'd2;
  localparam logic [7:0] OP_MOV_MR  = 8'd3;
  localparam logic [7:0] OP_MOV_LM  = 8'd4;
  localparam logic [7:0] OP_MOV_PR  = 8'd5;
  localparam logic [7:0] OP_MOV_OR  = 8'd6;
  localparam logic [7:0] OP_ADD_RR  = 8'd7;
  localparam logic [7:0] OP_ADD_LR  = 8'd8;
  localparam logic [7:0] OP_SUB_LR  = 8'd9;
  localparam logic [7:0] OP_SUB_RL  = 8'd10;
  localparam logic [7:0] OP_SUB_RR  = 8'd11;
  localparam logic [7:0] OP_MUL_LR  = 8'd12;
  localparam logic [7:0] OP_MUL_RR  = 8'd13;
  localparam logic [7:0] OP_INC     = 8'd14;
  localparam logic [7:0] OP_DEC     = 8'd15;
  localparam logic [7:0] OP_LSF_RL  = 8'd16;
  localparam logic [7:0] OP_LSF_RR  = 8'd17;
  localparam logic [7:0] OP_RSF_RL  = 8'd18;
  localparam logic [7:0] OP_RSF_RR  = 8'd19;
  localparam logic [7:0] OP_AND_RL  = 8'd20;
  localparam logic [7:0] OP_AND_RR  = 8'd21;
  localparam logic [7:0] OP_OR_RL   = 8'd22;
  localparam logic [7:0] OP_OR_RR   = 8'd23;
  localparam logic [7:0] OP_XOR_RL  = 8'd24;
  localparam logic [7:0] OP_XOR_RR  = 8'd25;
  localparam logic [7:0] OP_NOT     = 8'd26;
  localparam logic [7:0] OP_JNE_LIT = 8'd27;
  localparam logic [7:0] OP_JNE_REG = 8'd28;
  localparam logic [7:0] OP_JEQ_LIT = 8'd29;
  localparam logic [7:0] OP_JEQ_REG = 8'd30;
  localparam logic [7:0] OP_JLT_LIT = 8'd31;
  localparam logic [7:0] OP_JLT_REG = 8'd32;
  localparam logic [7:0] OP_JGT_LIT = 8'd33;
  localparam logic [7:0] OP_JGT_REG = 8'd34;
  localparam logic [7:0] OP_JLE_LIT = 8'd35;
  localparam logic [7:0] OP_JLE_REG = 8'd36;
  localparam logic [7:0] OP_JGE_LIT = 8'd37;
  localparam logic [7:0] OP_JGE_REG = 8'd38;
  localparam logic [7:0] OP_PSH_LIT = 8'd39;
  localparam logic [7:0] OP_PSH_REG = 8'd40;
  localparam logic [7:0] OP_POP     = 8'd41;
  localparam logic [7:0] OP_CAL_LIT = 8'd42;
  localparam logic [7:0] OP_CAL_REG = 8'd43;
  localparam logic [7:0] OP_RET     = 8'd44;
  localparam logic [7:0] OP_HLT     = 8'd45;

  typedef struct packed {
    logic       known;
    logic       first_w;
    logic       has_a;
    logic       has_b;
    logic [2:0] len;
  } op_fmt_t;

  typedef struct packed {
    logic [15:0] value;
    logic        wr_acc;
    logic        wr_a;
    logic        wr_b;
    logic        jump;
  } alu_res_t;

  function automatic op_fmt_t fmt_of(input logic [7:0] op);
    op_fmt_t f;
    f = '{known: 1'b1, first_w: 1'b0, has_a: 1'b0, has_b: 1'b0, len: 3'd0};
    unique case (op)
      OP_MOV_RR, OP_MOV_PR, OP_ADD_RR, OP_SUB_RR, OP_MUL_RR, OP_LSF_RR,
      OP_RSF_RR, OP_AND_RR, OP_OR_RR, OP_XOR_RR: begin
        f.has_a = 1'b1; f.has_b = 1'b1; f.len = 3'd2;
      end
      OP_MOV_RM, OP_SUB_RL, OP_LSF_RL, OP_RSF_RL, OP_AND_RL, OP_OR_RL,
      OP_XOR_RL, OP_JNE_REG, OP_JEQ_REG, OP_JLT_REG, OP_JGT_REG,
      OP_JLE_REG, OP_JGE_REG: begin
        f.has_a = 1'b1; f.len = 3'd3;
      end
      OP_MOV_LR, OP_MOV_MR, OP_ADD_LR, OP_SUB_LR, OP_MUL_LR: begin
        f.first_w = 1'b1; f.has_a = 1'b1; f.len = 3'd3;
      end
      OP_MOV_LM, OP_JNE_LIT, OP_JEQ_LIT, OP_JLT_LIT, OP_JGT_LIT,
      OP_JLE_LIT, OP_JGE_LIT: begin
        f.first_w = 1'b1; f.len = 3'd4;
      end
      OP_MOV_OR: begin
        f.first_w = 1'b1; f.has_a = 1'b1; f.has_b = 1'b1; f.len = 3'd4;
      end
      OP_INC, OP_DEC, OP_NOT, OP_PSH_REG, OP_POP, OP_CAL_REG: begin
        f.has_a = 1'b1; f.len = 3'd1;
      end
      OP_PSH_LIT, OP_CAL_LIT: begin
        f.first_w = 1'b1; f.len = 3'd2;
      end
      OP_RET, OP_HLT: f.len = 3'd0;
      default: f.known = 1'b0;
    endcase
    return f;
  endfunction

endpackage

// ===== sv/vm16_alu.sv =====
// register and accumulator arithmetic, shifts, logic and jump conditions
// depends on vm16_pkg
module vm16_alu (
  input  logic [7:0]          op,
  input  logic [15:0]         opa,
  input  logic [15:0]         opb,
  input  logic [15:0]         lit,
  input  logic [15:0]         acc,
  output vm16_pkg::alu_res_t  res
);
  import vm16_pkg::*;

  localparam logic [2:0] CC_NE = 3'd0;
  localparam logic [2:0] CC_EQ = 3'd1;
  localparam logic [2:0] CC_LT = 3'd2;
  localparam logic [2:0] CC_GT = 3'd3;
  localparam logic [2:0] CC_LE = 3'd4;

  logic [31:0] prod;
  logic [15:0] mul_x;
  logic [15:0] sh_amt;
  logic [15:0] shl_v;
  logic [15:0] shr_v;
  logic [7:0]  jrel;
  logic [2:0]  cc;
  logic [15:0] jv;
  logic        cond;

  always_comb begin
    mul_x = (op == OP_MUL_LR) ? lit : opb;
    prod  = mul_x * opa;
    sh_amt = (op == OP_LSF_RL || op == OP_RSF_RL) ? lit : opb;
    shl_v = (sh_amt >= 16'd16) ? 16'd0 : (opa << sh_amt[3:0]);
    shr_v = (sh_amt >= 16'd16) ? 16'd0 : (opa >> sh_amt[3:0]);
    jrel  = op - OP_JNE_LIT;
    cc    = jrel[3:1];
    jv    = jrel[0] ? opa : lit;
    unique case (cc)
      CC_NE:   cond = jv != acc;
      CC_EQ:   cond = jv == acc;
      CC_LT:   cond = jv < acc;
      CC_GT:   cond = jv > acc;
      CC_LE:   cond = jv <= acc;
      default: cond = jv >= acc;
    endcase
  end

  always_comb begin
    res = '0;
    unique case (op)
      OP_MOV_LR: begin res.value = lit; res.wr_a = 1'b1; end
      OP_MOV_RR: begin res.value = opa; res.wr_b = 1'b1; end
      OP_ADD_RR: begin res.value = opa + opb; res.wr_acc = 1'b1; end
      OP_ADD_LR: begin res.value = lit + opa; res.wr_acc = 1'b1; end
      OP_SUB_LR: begin res.value = opa - lit; res.wr_acc = 1'b1; end
      OP_SUB_RL: begin res.value = lit - opa; res.wr_acc = 1'b1; end
      OP_SUB_RR: begin res.value = opa - opb; res.wr_acc = 1'b1; end
      OP_MUL_LR, OP_MUL_RR: begin res.value = prod[15:0]; res.wr_acc = 1'b1; end
      OP_INC: begin res.value = opa + 16'd1; res.wr_a = 1'b1; end
      OP_DEC: begin res.value = opa - 16'd1; res.wr_a = 1'b1; end
      OP_LSF_RL, OP_LSF_RR: begin res.value = shl_v; res.wr_a = 1'b1; end
      OP_RSF_RL, OP_RSF_RR: begin res.value = shr_v; res.wr_a = 1'b1; end
      OP_AND_RL: begin res.value = opa & lit; res.wr_acc = 1'b1; end
      OP_AND_RR: begin res.value = opa & opb; res.wr_acc = 1'b1; end
      OP_OR_RL:  begin res.value = opa | lit; res.wr_acc = 1'b1; end
      OP_OR_RR:  begin res.value = opa | opb; res.wr_acc = 1'b1; end
      OP_XOR_RL: begin res.value = opa ^ lit; res.wr_acc = 1'b1; end
      OP_XOR_RR: begin res.value = opa ^ opb; res.wr_acc = 1'b1; end
      OP_NOT:    begin res.value = ~opa; res.wr_acc = 1'b1; end
      OP_JNE_LIT, OP_JNE_REG, OP_JEQ_LIT, OP_JEQ_REG, OP_JLT_LIT, OP_JLT_REG,
      OP_JGT_LIT, OP_JGT_REG, OP_JLE_LIT, OP_JLE_REG, OP_JGE_LIT,
      OP_JGE_REG: res.jump = cond;
      default: res = '0;
    endcase
  end

endmodule

// ===== sv/vm16_cpu_core_top.sv =====
// vm16 cpu core: 64 KiB byte memory, register file and step sequencer
// depends on vm16_pkg and vm16_alu
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+--------------------
//  request  | in_cmd in_mem_addr in_write_byte in_reg_select | in_valid / in_ready
//  result   | out_read_byte out_reg_value out_ip_now         | out_valid / out_ready
//           | out_acc_now out_sp_now out_halted out_fault    |
//
// one request at a time; a step fetches the instruction bytes, reads the register
// operands and executes, moving memory words a byte at a time through the single
// memory port; a return makes eleven word pops
// synchronous active-low reset clears registers and flags; memory is not cleared
// a new request is taken while a previous result still waits on out_ready
module vm16_cpu_core_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_mem_addr,
  input  logic [7:0]  in_write_byte,
  input  logic [3:0]  in_reg_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  output logic [15:0] out_reg_value,
  output logic [15:0] out_ip_now,
  output logic [15:0] out_acc_now,
  output logic [15:0] out_sp_now,
  output logic        out_halted,
  output logic        out_fault
);
  import vm16_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RDMEM, S_FETCH, S_REGA, S_REGB, S_EXEC,
    S_MWR_HI, S_MWR_LO, S_MRD_HI, S_MRD_LO, S_MRD_END,
    S_CALL_HI, S_CALL_LO, S_RET_HI, S_RET_LO, S_RET_END, S_DONE
  } state_t;

  state_t state_r;

  // byte memory
  logic [7:0]        mem_r [MEM_BYTES];
  logic [7:0]        mem_q_r;
  logic [MEM_AW-1:0] mem_a;
  logic [7:0]        mem_wd;
  logic              mem_we;

  // register file and frame state
  logic [15:0] regs_r   [REG_COUNT];
  logic [15:0] regs_nxt [REG_COUNT];
  logic [15:0] frame_r, frame_nxt;
  logic        halt_r;

  // per-step working registers
  logic [2:0]  cnt_r;
  logic [7:0]  op_r;
  logic [7:0]  ob_r [4];
  logic [15:0] opa_r, opb_r;
  logic [3:0]  k_r;
  logic [15:0] ra_r, wa_r, wd_r, target_r, saved_r;
  logic [7:0]  hi_r;
  logic [REG_IDX_W-1:0] dst_r;
  logic        push_r;
  logic        fault_r;
  logic [7:0]  rbyte_r;
  logic [15:0] rval_r;

  // result register
  logic        out_valid_r;
  logic [7:0]  out_read_byte_r;
  logic [15:0] out_reg_value_r, out_ip_r, out_acc_r, out_sp_r;
  logic        out_halted_r, out_fault_r;

  // decode
  op_fmt_t     fmt_cur, fmt_op;
  logic [2:0]  total;
  logic [7:0]  a_byte, b_byte;
  logic [15:0] w_a, w_b, jaddr, word, call_val;
  logic        bad, fault_c;
  logic [REG_IDX_W-1:0] rd_sel;
  logic [15:0] rf_rd;
  logic [15:0] ip, sp, fp;
  alu_res_t    alu_res;

  assign ip = regs_r[R_IP];
  assign sp = regs_r[R_SP];
  assign fp = regs_r[R_FP];

  assign fmt_cur = fmt_of((cnt_r == 3'd1) ? mem_q_r : op_r);
  assign total   = 3'd1 + fmt_cur.len;
  assign fmt_op  = fmt_of(op_r);

  // operand layout: either a word first or register bytes first
  assign a_byte = fmt_op.first_w ? ob_r[2] : ob_r[0];
  assign b_byte = fmt_op.first_w ? ob_r[3] : ob_r[1];
  assign w_a    = fmt_op.first_w ? {ob_r[0], ob_r[1]} : {ob_r[1], ob_r[2]};
  assign w_b    = {ob_r[2], ob_r[3]};
  assign bad    = (fmt_op.has_a && (a_byte >= 8'(REG_COUNT)))
               || (fmt_op.has_b && (b_byte >= 8'(REG_COUNT)));
  assign fault_c = !fmt_op.known || bad;
  // literal-form jumps carry value then target, register form a register then target
  assign jaddr  = fmt_op.first_w ? w_b : w_a;
  assign word   = {hi_r, mem_q_r};

  // single register read port
  always_comb begin
    unique case (state_r)
      S_IDLE:              rd_sel = in_reg_select;
      S_REGA:              rd_sel = a_byte[REG_IDX_W-1:0];
      S_REGB:              rd_sel = b_byte[REG_IDX_W-1:0];
      S_CALL_HI, S_CALL_LO: rd_sel = R_R1 + k_r;
      default:             rd_sel = a_byte[REG_IDX_W-1:0];
    endcase
    rf_rd = (32'(rd_sel) < REG_COUNT) ? regs_r[rd_sel] : 16'd0;
  end

  // call pushes r1..r8, return address, then frame size
  always_comb begin
    if (k_r < 4'd8)       call_val = rf_rd;
    else if (k_r == 4'd8) call_val = ip;
    else                  call_val = frame_r + 16'd2;
  end

  vm16_alu u_alu (
    .op  (op_r),
    .opa (opa_r),
    .opb (opb_r),
    .lit (w_a),
    .acc (regs_r[R_ACC]),
    .res (alu_res)
  );

  // memory port address and write data
  always_comb begin
    mem_a  = in_mem_addr;
    mem_wd = in_write_byte;
    mem_we = 1'b0;
    unique case (state_r)
      S_IDLE:    mem_we = in_valid && (in_cmd == CMD_WR);
      S_FETCH:   mem_a = ip;
      S_MRD_HI:  mem_a = ra_r;
      S_MRD_LO:  mem_a = ra_r + 16'd1;
      S_MWR_HI:  begin mem_a = wa_r; mem_wd = wd_r[15:8]; mem_we = 1'b1; end
      S_MWR_LO:  begin mem_a = wa_r + 16'd1; mem_wd = wd_r[7:0]; mem_we = 1'b1; end
      S_CALL_HI: begin mem_a = sp; mem_wd = call_val[15:8]; mem_we = 1'b1; end
      S_CALL_LO: begin mem_a = sp + 16'd1; mem_wd = call_val[7:0]; mem_we = 1'b1; end
      S_RET_HI:  mem_a = sp + 16'd2;
      S_RET_LO:  mem_a = sp + 16'd1;
      default:   mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_a] <= mem_wd;
    mem_q_r <= mem_r[mem_a];
  end

  // register file next value
  always_comb begin
    regs_nxt  = regs_r;
    frame_nxt = frame_r;
    unique case (state_r)
      S_FETCH: if (cnt_r < total) regs_nxt[R_IP] = ip + 16'd1;
      S_EXEC: if (!fault_c) begin
        if (alu_res.wr_acc) regs_nxt[R_ACC] = alu_res.value;
        if (alu_res.wr_a)   regs_nxt[a_byte[REG_IDX_W-1:0]] = alu_res.value;
        if (alu_res.wr_b)   regs_nxt[b_byte[REG_IDX_W-1:0]] = alu_res.value;
        if (alu_res.jump)   regs_nxt[R_IP] = jaddr;
        if (op_r == OP_POP) begin
          regs_nxt[R_SP] = sp + 16'd2;
          frame_nxt      = frame_r - 16'd2;
        end
        if (op_r == OP_RET) regs_nxt[R_SP] = fp;
      end
      S_MWR_LO: if (push_r) begin
        regs_nxt[R_SP] = sp - 16'd2;
        frame_nxt      = frame_r + 16'd2;
      end
      S_MRD_END: regs_nxt[dst_r] = word;
      S_CALL_LO: begin
        regs_nxt[R_SP] = sp - 16'd2;
        frame_nxt      = frame_r + 16'd2;
        if (k_r == 4'd9) begin
          regs_nxt[R_FP] = sp - 16'd2;
          frame_nxt      = 16'd0;
          regs_nxt[R_IP] = target_r;
        end
      end
      S_RET_HI: regs_nxt[R_SP] = sp + 16'd2;
      S_RET_END: begin
        if (k_r == 4'd0) begin
          frame_nxt = word;
        end else if (k_r == 4'd1) begin
          regs_nxt[R_IP] = word;
          frame_nxt      = frame_r - 16'd2;
        end else if (k_r < 4'd10) begin
          regs_nxt[(R_R8 + 4'd2) - k_r] = word;
          frame_nxt = frame_r - 16'd2;
        end else begin
          // drop the argument words and restore the caller frame
          regs_nxt[R_SP] = sp + {word[14:0], 1'b0};
          frame_nxt      = frame_r - 16'd2 - {word[14:0], 1'b0};
          regs_nxt[R_FP] = fp + saved_r;
        end
      end
      default: frame_nxt = frame_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= 16'd0;
      regs_r[R_SP] <= RESET_SP;
      regs_r[R_FP] <= RESET_SP;
      frame_r      <= 16'd0;
    end else begin
      regs_r  <= regs_nxt;
      frame_r <= frame_nxt;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      halt_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          rbyte_r <= 8'd0;
          rval_r  <= 16'd0;
          fault_r <= 1'b0;
          unique case (in_cmd)
            CMD_WR:  state_r <= S_DONE;
            CMD_RD:  state_r <= S_RDMEM;
            CMD_REG: begin rval_r <= rf_rd; state_r <= S_DONE; end
            default: begin
              cnt_r   <= 3'd0;
              state_r <= halt_r ? S_DONE : S_FETCH;
            end
          endcase
        end
        S_RDMEM: begin rbyte_r <= mem_q_r; state_r <= S_DONE; end
        S_FETCH: begin
          if (cnt_r == 3'd1) op_r <= mem_q_r;
          else if (cnt_r >= 3'd2) ob_r[2'(cnt_r - 3'd2)] <= mem_q_r;
          if (cnt_r < total) cnt_r <= cnt_r + 3'd1;
          else               state_r <= S_REGA;
        end
        S_REGA: begin opa_r <= rf_rd; state_r <= S_REGB; end
        S_REGB: begin opb_r <= rf_rd; state_r <= S_EXEC; end
        S_EXEC: begin
          dst_r  <= a_byte[REG_IDX_W-1:0];
          push_r <= 1'b0;
          k_r    <= 4'd0;
          if (fault_c) begin
            fault_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            unique case (op_r)
              OP_MOV_RM: begin wa_r <= w_a; wd_r <= opa_r; state_r <= S_MWR_HI; end
              OP_MOV_LM: begin wa_r <= w_b; wd_r <= w_a; state_r <= S_MWR_HI; end
              OP_PSH_LIT: begin
                wa_r <= sp; wd_r <= w_a; push_r <= 1'b1; state_r <= S_MWR_HI;
              end
              OP_PSH_REG: begin
                wa_r <= sp; wd_r <= opa_r; push_r <= 1'b1; state_r <= S_MWR_HI;
              end
              OP_MOV_MR: begin ra_r <= w_a; state_r <= S_MRD_HI; end
              OP_MOV_PR: begin
                ra_r <= opa_r; dst_r <= b_byte[REG_IDX_W-1:0]; state_r <= S_MRD_HI;
              end
              OP_MOV_OR: begin
                ra_r <= w_a + opa_r; dst_r <= b_byte[REG_IDX_W-1:0];
                state_r <= S_MRD_HI;
              end
              OP_POP:     begin ra_r <= sp + 16'd2; state_r <= S_MRD_HI; end
              OP_CAL_LIT: begin target_r <= w_a; state_r <= S_CALL_HI; end
              OP_CAL_REG: begin target_r <= opa_r; state_r <= S_CALL_HI; end
              OP_RET:     state_r <= S_RET_HI;
              OP_HLT:     begin halt_r <= 1'b1; state_r <= S_DONE; end
              default:    state_r <= S_DONE;
            endcase
          end
        end
        S_MWR_HI:  state_r <= S_MWR_LO;
        S_MWR_LO:  state_r <= S_DONE;
        S_MRD_HI:  state_r <= S_MRD_LO;
        S_MRD_LO:  begin hi_r <= mem_q_r; state_r <= S_MRD_END; end
        S_MRD_END: state_r <= S_DONE;
        S_CALL_HI: state_r <= S_CALL_LO;
        S_CALL_LO: begin
          k_r     <= k_r + 4'd1;
          state_r <= (k_r == 4'd9) ? S_DONE : S_CALL_HI;
        end
        S_RET_HI: state_r <= S_RET_LO;
        S_RET_LO: begin hi_r <= mem_q_r; state_r <= S_RET_END; end
        S_RET_END: begin
          if (k_r == 4'd0) saved_r <= word;
          k_r     <= k_r + 4'd1;
          state_r <= (k_r == 4'd10) ? S_DONE : S_RET_HI;
        end
        S_DONE: if (!out_valid_r || out_ready) begin
          out_valid_r     <= 1'b1;
          out_read_byte_r <= rbyte_r;
          out_reg_value_r <= rval_r;
          out_ip_r        <= ip;
          out_acc_r       <= regs_r[R_ACC];
          out_sp_r        <= sp;
          out_halted_r    <= halt_r;
          out_fault_r     <= fault_r;
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_byte = out_read_byte_r;
  assign out_reg_value = out_reg_value_r;
  assign out_ip_now    = out_ip_r;
  assign out_acc_now   = out_acc_r;
  assign out_sp_now    = out_sp_r;
  assign out_halted    = out_halted_r;
  assign out_fault     = out_fault_r;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for vm16_cpu_core_top: a cycle-free predictor of the core runs
// beside the rtl and every result is compared field by field
// depends on vm16_pkg and the rtl of vm16_cpu_core_top
module tb_top;
  import vm16_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // expected fields of one result
  typedef struct {
    logic [7:0]  rbyte;
    logic [15:0] rval;
    logic [15:0] ip;
    logic [15:0] acc;
    logic [15:0] sp;
    logic        halted;
    logic        fault;
  } core_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_RD;
  logic [15:0] in_mem_addr = '0;
  logic [7:0]  in_write_byte = '0;
  logic [3:0]  in_reg_select = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_byte;
  logic [15:0] out_reg_value;
  logic [15:0] out_ip_now;
  logic [15:0] out_acc_now;
  logic [15:0] out_sp_now;
  logic        out_halted;
  logic        out_fault;

  // shadow of the core: memory, register file, frame size and halt flag
  logic [7:0]  shadow_mem [0:MEM_BYTES-1];
  logic [15:0] shadow_reg [0:15];
  logic [15:0] shadow_frame;
  logic        shadow_halt;
  logic        shadow_bad_reg;

  core_view_t  pending_views[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // clock: 4 ns period
  always #2 clk = ~clk;

  vm16_cpu_core_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_mem_addr   (in_mem_addr),
    .in_write_byte (in_write_byte),
    .in_reg_select (in_reg_select),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_byte (out_read_byte),
    .out_reg_value (out_reg_value),
    .out_ip_now    (out_ip_now),
    .out_acc_now   (out_acc_now),
    .out_sp_now    (out_sp_now),
    .out_halted    (out_halted),
    .out_fault     (out_fault)
  );

  // ---------------------------------------------------------------------------
  // predictor of the core
  // ---------------------------------------------------------------------------

  // big-endian word access, addresses wrap at 16 bits
  function automatic logic [15:0] mem_word(input logic [15:0] addr);
    logic [15:0] nxt;
    nxt = addr + 16'd1;
    return {shadow_mem[addr], shadow_mem[nxt]};
  endfunction

  function automatic void mem_word_wr(input logic [15:0] addr, input logic [15:0] value);
    logic [15:0] nxt;
    nxt = addr + 16'd1;
    shadow_mem[addr] = value[15:8];
    shadow_mem[nxt]  = value[7:0];
  endfunction

  function automatic logic [7:0] next_byte();
    logic [7:0] b;
    b = shadow_mem[shadow_reg[R_IP]];
    shadow_reg[R_IP] = shadow_reg[R_IP] + 16'd1;
    return b;
  endfunction

  function automatic logic [15:0] next_word();
    logic [15:0] w;
    w = mem_word(shadow_reg[R_IP]);
    shadow_reg[R_IP] = shadow_reg[R_IP] + 16'd2;
    return w;
  endfunction

  // register operand; an index past the file marks the instruction as faulty
  function automatic logic [3:0] next_reg();
    logic [7:0] r;
    r = next_byte();
    if (r >= REG_COUNT) shadow_bad_reg = 1'b1;
    return r[3:0];
  endfunction

  function automatic void stack_push(input logic [15:0] value);
    mem_word_wr(shadow_reg[R_SP], value);
    shadow_reg[R_SP] = shadow_reg[R_SP] - 16'd2;
    shadow_frame = shadow_frame + 16'd2;
  endfunction

  function automatic logic [15:0] stack_pop();
    shadow_reg[R_SP] = shadow_reg[R_SP] + 16'd2;
    shadow_frame = shadow_frame - 16'd2;
    return mem_word(shadow_reg[R_SP]);
  endfunction

  // saves r1..r8, ip and the frame size, then opens an empty frame
  function automatic void enter_call(input logic [15:0] target);
    for (int i = 2; i <= 9; i++) stack_push(shadow_reg[i]);
    stack_push(shadow_reg[R_IP]);
    stack_push(shadow_frame + 16'd2);
    shadow_reg[R_FP] = shadow_reg[R_SP];
    shadow_frame = '0;
    shadow_reg[R_IP] = target;
  endfunction

  // unwinds the frame and drops the argument words
  function automatic void leave_call();
    logic [15:0] fp0;
    logic [15:0] saved;
    logic [15:0] nargs;
    fp0 = shadow_reg[R_FP];
    shadow_reg[R_SP] = fp0;
    saved = stack_pop();
    shadow_frame = saved;
    shadow_reg[R_IP] = stack_pop();
    for (int i = 9; i >= 2; i--) shadow_reg[i] = stack_pop();
    nargs = stack_pop();
    shadow_reg[R_SP] = shadow_reg[R_SP] + (nargs << 1);
    shadow_frame = shadow_frame - (nargs << 1);
    shadow_reg[R_FP] = fp0 + saved;
  endfunction

  function automatic logic [15:0] shift_left(input logic [15:0] v, input logic [15:0] s);
    return (s >= 16) ? 16'd0 : 16'(v << s);
  endfunction

  function automatic logic [15:0] shift_right(input logic [15:0] v, input logic [15:0] s);
    return (s >= 16) ? 16'd0 : (v >> s);
  endfunction

  // unsigned compare of the operand against acc
  function automatic logic jump_taken(input int k, input logic [15:0] v, input logic [15:0] a);
    case (k)
      0: return v != a;
      1: return v == a;
      2: return v < a;
      3: return v > a;
      4: return v <= a;
      default: return v >= a;
    endcase
  endfunction

  // executes one instruction on the shadow state, returns the fault flag
  function automatic logic execute_instr(input logic [7:0] op);
    logic [3:0]  a;
    logic [3:0]  b;
    logic [15:0] lit;
    logic [15:0] addr;
    logic [15:0] v;
    shadow_bad_reg = 1'b0;
    if (op >= OP_JNE_LIT && op <= OP_JGE_REG) begin
      if ((op - OP_JNE_LIT) % 2 == 1) begin
        a = next_reg(); addr = next_word(); v = shadow_reg[a];
      end else begin
        v = next_word(); addr = next_word();
      end
      if (!shadow_bad_reg && jump_taken((op - OP_JNE_LIT) / 2, v, shadow_reg[R_ACC]))
        shadow_reg[R_IP] = addr;
      return shadow_bad_reg;
    end
    case (op)
      OP_MOV_LR: begin
        lit = next_word(); a = next_reg(); if (!shadow_bad_reg) shadow_reg[a] = lit;
      end
      OP_MOV_RR: begin
        a = next_reg(); b = next_reg(); if (!shadow_bad_reg) shadow_reg[b] = shadow_reg[a];
      end
      OP_MOV_RM: begin
        a = next_reg(); addr = next_word(); if (!shadow_bad_reg) mem_word_wr(addr, shadow_reg[a]);
      end
      OP_MOV_MR: begin
        addr = next_word(); a = next_reg(); if (!shadow_bad_reg) shadow_reg[a] = mem_word(addr);
      end
      OP_MOV_LM: begin
        lit = next_word(); addr = next_word(); mem_word_wr(addr, lit);
      end
      OP_MOV_PR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[b] = mem_word(shadow_reg[a]);
      end
      OP_MOV_OR: begin
        addr = next_word(); a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[b] = mem_word(addr + shadow_reg[a]);
      end
      OP_ADD_RR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] + shadow_reg[b];
      end
      OP_ADD_LR: begin
        lit = next_word(); a = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = lit + shadow_reg[a];
      end
      OP_SUB_LR: begin
        lit = next_word(); a = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] - lit;
      end
      OP_SUB_RL: begin
        a = next_reg(); lit = next_word();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = lit - shadow_reg[a];
      end
      OP_SUB_RR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] - shadow_reg[b];
      end
      OP_MUL_LR: begin
        lit = next_word(); a = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = 16'(lit * shadow_reg[a]);
      end
      OP_MUL_RR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = 16'(shadow_reg[a] * shadow_reg[b]);
      end
      OP_INC: begin
        a = next_reg(); if (!shadow_bad_reg) shadow_reg[a] = shadow_reg[a] + 16'd1;
      end
      OP_DEC: begin
        a = next_reg(); if (!shadow_bad_reg) shadow_reg[a] = shadow_reg[a] - 16'd1;
      end
      OP_LSF_RL: begin
        a = next_reg(); lit = next_word();
        if (!shadow_bad_reg) shadow_reg[a] = shift_left(shadow_reg[a], lit);
      end
      OP_LSF_RR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[a] = shift_left(shadow_reg[a], shadow_reg[b]);
      end
      OP_RSF_RL: begin
        a = next_reg(); lit = next_word();
        if (!shadow_bad_reg) shadow_reg[a] = shift_right(shadow_reg[a], lit);
      end
      OP_RSF_RR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[a] = shift_right(shadow_reg[a], shadow_reg[b]);
      end
      OP_AND_RL: begin
        a = next_reg(); lit = next_word();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] & lit;
      end
      OP_AND_RR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] & shadow_reg[b];
      end
      OP_OR_RL: begin
        a = next_reg(); lit = next_word();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] | lit;
      end
      OP_OR_RR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] | shadow_reg[b];
      end
      OP_XOR_RL: begin
        a = next_reg(); lit = next_word();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] ^ lit;
      end
      OP_XOR_RR: begin
        a = next_reg(); b = next_reg();
        if (!shadow_bad_reg) shadow_reg[R_ACC] = shadow_reg[a] ^ shadow_reg[b];
      end
      OP_NOT: begin
        a = next_reg(); if (!shadow_bad_reg) shadow_reg[R_ACC] = ~shadow_reg[a];
      end
      OP_PSH_LIT: begin
        lit = next_word(); stack_push(lit);
      end
      OP_PSH_REG: begin
        a = next_reg(); if (!shadow_bad_reg) stack_push(shadow_reg[a]);
      end
      OP_POP: begin
        a = next_reg();
        if (!shadow_bad_reg) begin
          lit = stack_pop();
          shadow_reg[a] = lit;
        end
      end
      OP_CAL_LIT: begin
        addr = next_word(); enter_call(addr);
      end
      OP_CAL_REG: begin
        a = next_reg(); if (!shadow_bad_reg) enter_call(shadow_reg[a]);
      end
      OP_RET: leave_call();
      OP_HLT: shadow_halt = 1'b1;
      default: return 1'b1;
    endcase
    return shadow_bad_reg;
  endfunction

  // applies one request to the shadow state and returns the result it causes
  function automatic core_view_t predict_request(input logic [1:0] cmd, input logic [15:0] addr,
                                                 input logic [7:0] wbyte, input logic [3:0] sel);
    core_view_t v;
    v.rbyte = '0;
    v.rval  = '0;
    v.fault = 1'b0;
    case (cmd)
      CMD_WR:   shadow_mem[addr] = wbyte;
      CMD_STEP: if (!shadow_halt) v.fault = execute_instr(next_byte());
      CMD_RD:   v.rbyte = shadow_mem[addr];
      default:  if (sel < REG_COUNT) v.rval = shadow_reg[sel];
    endcase
    v.ip     = shadow_reg[R_IP];
    v.acc    = shadow_reg[R_ACC];
    v.sp     = shadow_reg[R_SP];
    v.halted = shadow_halt;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver and result checker
  // ---------------------------------------------------------------------------

  // drives one request at the falling edge and holds it until taken
  task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
                              input logic [7:0] wbyte, input logic [3:0] sel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pending_views.push_back(predict_request(cmd, addr, wbyte, sel));
    in_cmd        <= cmd;
    in_mem_addr   <= addr;
    in_write_byte <= wbyte;
    in_reg_select <= sel;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %0t: %s got %h expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // receiver back-pressure, redrawn each falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    core_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        if (out_read_byte !== want.rbyte) report_mismatch("read_byte", out_read_byte, want.rbyte);
        if (out_reg_value !== want.rval) report_mismatch("reg_value", out_reg_value, want.rval);
        if (out_ip_now !== want.ip) report_mismatch("ip_now", out_ip_now, want.ip);
        if (out_acc_now !== want.acc) report_mismatch("acc_now", out_acc_now, want.acc);
        if (out_sp_now !== want.sp) report_mismatch("sp_now", out_sp_now, want.sp);
        if (out_halted !== want.halted) report_mismatch("halted", out_halted, want.halted);
        if (out_fault !== want.fault) report_mismatch("fault", out_fault, want.fault);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // instruction building
  // ---------------------------------------------------------------------------

  // operand layout after the opcode byte: W a big-endian word, R a register byte
  function automatic string operand_shape(input logic [7:0] op);
    if (op >= OP_JNE_LIT && op <= OP_JGE_REG)
      return ((op - OP_JNE_LIT) % 2 == 1) ? "RW" : "WW";
    case (op)
      OP_MOV_LR, OP_MOV_MR, OP_ADD_LR, OP_SUB_LR, OP_MUL_LR: return "WR";
      OP_MOV_RR, OP_MOV_PR, OP_ADD_RR, OP_SUB_RR, OP_MUL_RR, OP_LSF_RR, OP_RSF_RR,
      OP_AND_RR, OP_OR_RR, OP_XOR_RR: return "RR";
      OP_MOV_RM, OP_SUB_RL, OP_LSF_RL, OP_RSF_RL, OP_AND_RL, OP_OR_RL, OP_XOR_RL: return "RW";
      OP_MOV_LM: return "WW";
      OP_MOV_OR: return "WRR";
      OP_INC, OP_DEC, OP_NOT, OP_PSH_REG, OP_POP, OP_CAL_REG: return "R";
      OP_PSH_LIT, OP_CAL_LIT: return "W";
      default: return "";
    endcase
  endfunction

  // writes the instruction at the current ip and steps it; words and registers
  // fill the slots of each kind in order
  task automatic run_instr(input logic [7:0] op, input logic [15:0] w0, input logic [15:0] w1,
                           input logic [7:0] r0, input logic [7:0] r1);
    string       shape;
    logic [7:0]  code[$];
    logic [15:0] words[2];
    logic [7:0]  regs[2];
    int          wi;
    int          ri;
    logic [15:0] at;
    shape = operand_shape(op);
    words[0] = w0; words[1] = w1;
    regs[0] = r0;  regs[1] = r1;
    wi = 0;
    ri = 0;
    code.push_back(op);
    for (int i = 0; i < shape.len(); i++) begin
      if (shape[i] == "W") begin
        code.push_back(words[wi][15:8]);
        code.push_back(words[wi][7:0]);
        wi++;
      end else begin
        // a third register slot, if any shape had one, would reuse the last register
        code.push_back(regs[(ri > 1) ? 1 : ri]);
        ri++;
      end
    end
    at = shadow_reg[R_IP];
    foreach (code[i]) send_request(CMD_WR, at + 16'(i), code[i], '0);
    send_request(CMD_STEP, '0, '0, '0);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(20));
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly valid register indexes, sometimes past the file
  function automatic logic [7:0] pick_reg();
    if ($urandom_range(99) < 5) return 8'($urandom_range(REG_COUNT, 255));
    return 8'($urandom_range(REG_COUNT - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers straight after reset, including the indexes that read zero
  task automatic test_reset_state();
    for (int i = 0; i < 16; i++) send_request(CMD_REG, '0, '0, 4'(i));
  endtask

  // every byte is written at least once so that no fetch or load can hit unwritten memory
  task automatic test_memory_fill();
    for (int i = 0; i < MEM_BYTES; i++) send_request(CMD_WR, 16'(i), 8'($urandom), '0);
    send_request(CMD_RD, 16'h0000, '0, '0);
    send_request(CMD_RD, 16'hffff, '0, '0);
    send_request(CMD_WR, 16'hffff, 8'hff, '0);
    send_request(CMD_WR, 16'h0000, 8'h00, '0);
    send_request(CMD_RD, 16'hffff, '0, '0);
  endtask

  // directed corner cases, then every opcode but halt once with random operands
  task automatic test_directed();
    logic [7:0] op;
    run_instr(OP_MOV_LR, 16'hffff, 0, 2, 0);
    run_instr(OP_MOV_LR, 16'h0001, 0, 3, 0);
    run_instr(OP_ADD_RR, 0, 0, 2, 3);              // carry out is lost
    run_instr(OP_MUL_LR, 16'hffff, 0, 2, 0);       // product wraps
    run_instr(OP_LSF_RL, 0, 16'd16, 2, 0);         // literal slot gets the first word, so the shift is by 0
    run_instr(OP_MOV_LR, 16'h8001, 0, 4, 0);
    run_instr(OP_RSF_RL, 0, 16'd15, 4, 0);
    run_instr(OP_SUB_RL, 0, 16'h0000, 3, 0);
    run_instr(OP_NOT, 0, 0, 4, 0);
    run_instr(OP_MOV_RR, 0, 0, 3, 12);             // destination past the file
    run_instr(OP_INC, 0, 0, 15, 0);
    run_instr(8'd46, 0, 0, 0, 0);                  // first unknown opcode
    run_instr(8'd255, 0, 0, 0, 0);
    run_instr(OP_MOV_LM, 16'habcd, 16'hffff, 0, 0);// word straddles the top address
    run_instr(OP_PSH_LIT, 16'd2, 0, 0, 0);         // argument count
    run_instr(OP_CAL_LIT, 16'h4000, 0, 0, 0);
    run_instr(OP_PSH_REG, 0, 0, 2, 0);
    run_instr(OP_POP, 0, 0, 5, 0);
    run_instr(OP_RET, 0, 0, 0, 0);                 // drops the argument words
    run_instr(OP_JEQ_LIT, 16'h1234, 16'h2000, 0, 0);
    run_instr(OP_JLT_REG, 0, 16'h3000, 3, 0);
    send_request(CMD_REG, '0, '0, 4'd12);
    for (int i = 0; i < OP_HLT; i++) begin
      op = 8'(i);
      run_instr(op, pick_word(), pick_word(), pick_reg(), pick_reg());
    end
  endtask

  // random instruction streams with occasional probes, unknown opcodes and
  // stray memory writes; halt is left to the last test
  task automatic test_random_program(input int unsigned count);
    logic [7:0] op;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 4) op = 8'($urandom_range(OP_HLT + 1, 255));
      else if ($urandom_range(99) < 12) op = ($urandom_range(1)) ? OP_CAL_LIT : OP_RET;
      else op = 8'($urandom_range(OP_RET));
      run_instr(op, pick_word(), pick_word(), pick_reg(), pick_reg());
      if ($urandom_range(99) < 25) send_request(CMD_REG, '0, '0, 4'($urandom_range(15)));
      if ($urandom_range(99) < 10) send_request(CMD_RD, 16'($urandom), '0, '0);
      if ($urandom_range(99) < 5) send_request(CMD_WR, 16'($urandom), 8'($urandom), '0);
    end
  endtask

  // after a halt, steps leave everything alone
  task automatic test_halt();
    run_instr(OP_HLT, 0, 0, 0, 0);
    run_instr(OP_INC, 0, 0, 1, 0);
    send_request(CMD_STEP, '0, '0, '0);
    send_request(CMD_REG, '0, '0, 4'd1);
    send_request(CMD_RD, 16'h0000, '0, '0);
  endtask

  initial begin
    shadow_frame = '0;
    shadow_halt  = 1'b0;
    foreach (shadow_reg[i]) shadow_reg[i] = '0;
    shadow_reg[R_SP] = RESET_SP;
    shadow_reg[R_FP] = RESET_SP;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_memory_fill();
    test_directed();

    // no idling
    test_random_program(70);
    // sender idle about half the time
    send_idle_pct = 51;
    test_random_program(70);
    // receiver stalling about half the time
    send_idle_pct = 0;
    recv_stall_pct = 51;
    test_random_program(70);
    // light idling on both sides
    send_idle_pct = 14;
    recv_stall_pct = 14;
    test_random_program(70);

    test_halt();
    in_valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_views.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vm16_pkg.sv
sv/vm16_alu.sv
sv/vm16_cpu_core_top.sv
tb/tb_top.sv
